// ===== rtl/core/ssrl_pkg.sv =====
// shared types and constants of the sorted symbol range lookup unit
`timescale 1ns / 1ps

package ssrl_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);

	// fixed field widths
	localparam int ADDR_W    = 64;
	localparam int INDEX_W   = 10;
	localparam int COUNT_W   = 11;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_ORIGIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOAD_BASE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOAD_END    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd3;

	// input beat function codes
	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	// lookup outcome codes
	typedef enum logic [1:0] {
		ST_HIT   = 2'd0,
		ST_LAST  = 2'd1,
		ST_BELOW = 2'd2,
		ST_NONE  = 2'd3
	} status_t;

	// commands from controller to datapath
	typedef struct packed {
		logic    wr_entry;
		logic    ld_query;
		logic    ld_key;
		logic    rd_ends;
		logic    rd_mid;
		logic    cmp_ends;
		logic    cmp_mid;
		logic    res_load;
		status_t res_kind;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic empty;
		logic below;
		logic above_b;
		logic lo_eq_hi;
	} stat_t;

endpackage

// ===== rtl/core/ssrl_ctrl.sv =====
// controller state machine of the sorted symbol range lookup unit
`timescale 1ns / 1ps

module ssrl_ctrl import ssrl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  func,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy
);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_KEY      = 7'b0000010,
		S_ENDS_RD  = 7'b0000100,
		S_ENDS_CMP = 7'b0001000,
		S_SRCH_RD  = 7'b0010000,
		S_SRCH_CMP = 7'b0100000,
		S_OUT      = 7'b1000000
	} state_t;

	state_t  state_q, state_d;
	status_t kind_q, kind_d;

	// state and outcome registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= ST_NONE;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	// next state and command decode
	always_comb begin
		state_d      = state_q;
		kind_d       = kind_q;
		cmd          = '0;
		cmd.res_kind = kind_q;
		case (state_q)
			S_IDLE: begin
				if (start && !func) begin
					cmd.wr_entry = 1'b1;
				end else if (start && func) begin
					cmd.ld_query = 1'b1;
					if (stat.empty) begin
						kind_d  = ST_NONE;
						state_d = S_OUT;
					end else begin
						state_d = S_KEY;
					end
				end
			end
			S_KEY: begin
				cmd.ld_key = 1'b1;
				state_d    = S_ENDS_RD;
			end
			S_ENDS_RD: begin
				cmd.rd_ends = 1'b1;
				state_d     = S_ENDS_CMP;
			end
			S_ENDS_CMP: begin
				cmd.cmp_ends = 1'b1;
				if (stat.below) begin
					kind_d  = ST_BELOW;
					state_d = S_OUT;
				end else if (stat.above_b) begin
					kind_d  = ST_LAST;
					state_d = S_OUT;
				end else begin
					state_d = S_SRCH_RD;
				end
			end
			S_SRCH_RD: begin
				if (stat.lo_eq_hi) begin
					kind_d  = ST_NONE;
					state_d = S_OUT;
				end else begin
					cmd.rd_mid = 1'b1;
					state_d    = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				cmd.cmp_mid = 1'b1;
				if (!stat.below && !stat.above_b) begin
					kind_d  = ST_HIT;
					state_d = S_OUT;
				end else begin
					state_d = S_SRCH_RD;
				end
			end
			S_OUT: begin
				cmd.res_load = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	// result step always returns to idle
	a_out_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT |=> state_q == S_IDLE)
		else $error("result step did not return to idle");

	// lookup on an empty table goes straight to the result step
	a_empty_short: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start && func && stat.empty) |=> state_q == S_OUT)
		else $error("empty table lookup did not skip the search");

	// a failed probe continues the search
	a_probe_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH_CMP && (stat.below || stat.above_b)) |=> state_q == S_SRCH_RD)
		else $error("search probe miss did not continue");

endmodule

// ===== rtl/core/ssrl_dp.sv =====
// datapath of the sorted symbol range lookup unit: registers, table, search bounds
`timescale 1ns / 1ps

module ssrl_dp import ssrl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output stat_t                stat,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  logic [INDEX_W-1:0]   write_index,
	input  logic [ADDR_W-1:0]    entry_start,
	input  logic [ADDR_W-1:0]    query_address,
	output logic                 done,
	output logic [1:0]           status,
	output logic [INDEX_W-1:0]   found_index,
	output logic [ADDR_W-1:0]    next_boundary
);

	logic [ADDR_W-1:0]  text_origin_q, load_base_q, load_end_q;
	logic [COUNT_W-1:0] entry_count_q;

	logic [ADDR_W-1:0]  mem [TABLE_DEPTH];
	logic [ADDR_W-1:0]  rd_a_q, rd_b_q;
	logic [IDX_W-1:0]   addr_a, addr_b;

	logic [ADDR_W-1:0]  diff_q, key_q, tmp_q;
	logic [IDX_W-1:0]   lo_q, hi_q, hi_init, mid, mid_p1;
	logic [IDX_W:0]     bound_sum;
	logic [31:0]        count_ext;
	logic               wr_ok;

	logic               done_q;
	status_t            status_q;
	logic [INDEX_W-1:0] found_index_q;
	logic [ADDR_W-1:0]  next_boundary_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_origin_q <= '0;
			load_base_q   <= '0;
			load_end_q    <= '0;
			entry_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEXT_ORIGIN: text_origin_q <= cfg_data;
				REG_LOAD_BASE:   load_base_q   <= cfg_data;
				REG_LOAD_END:    load_end_q    <= cfg_data;
				REG_ENTRY_COUNT: entry_count_q <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// search bounds: midpoint and its neighbor
	assign bound_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = bound_sum[IDX_W:1];
	assign mid_p1    = mid + 1'b1;

	// last usable index, count clamped to the table depth
	assign count_ext = 32'(entry_count_q);
	assign hi_init   = (count_ext > 32'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1)
	                                                  : IDX_W'(count_ext - 32'd1);
	assign wr_ok     = (32'(write_index) < 32'(TABLE_DEPTH));

	// read addresses: table ends or probe pair
	assign addr_a = cmd.rd_mid ? mid    : '0;
	assign addr_b = cmd.rd_mid ? mid_p1 : hi_q;

	// start address table, one write port and two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.wr_entry && wr_ok) begin
			mem[IDX_W'(write_index)] <= entry_start;
		end
		if (cmd.rd_ends || cmd.rd_mid) begin
			rd_a_q <= mem[addr_a];
			rd_b_q <= mem[addr_b];
		end
	end

	// compare results toward the controller
	assign stat.empty    = (entry_count_q == '0);
	assign stat.below    = (key_q < rd_a_q);
	assign stat.above_b  = (key_q >= rd_b_q);
	assign stat.lo_eq_hi = (lo_q == hi_q);

	// key rebasing, bound updates, boundary offset
	always_ff @(posedge clk) begin
		if (cmd.ld_query) begin
			diff_q <= query_address - load_base_q;
			lo_q   <= '0;
			hi_q   <= hi_init;
		end
		if (cmd.ld_key) begin
			key_q <= text_origin_q + diff_q;
		end
		if (cmd.cmp_ends) begin
			tmp_q <= rd_a_q - text_origin_q;
		end
		if (cmd.cmp_mid) begin
			tmp_q <= rd_b_q - text_origin_q;
			if (stat.below) begin
				hi_q <= mid;
			end else if (stat.above_b) begin
				lo_q <= mid_p1;
			end
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q <= cmd.res_kind;
			case (cmd.res_kind)
				ST_HIT: begin
					found_index_q   <= INDEX_W'(mid);
					next_boundary_q <= load_base_q + tmp_q;
				end
				ST_LAST: begin
					found_index_q   <= INDEX_W'(hi_q);
					next_boundary_q <= load_end_q;
				end
				ST_BELOW: begin
					found_index_q   <= '0;
					next_boundary_q <= load_base_q + tmp_q;
				end
				default: begin
					found_index_q   <= '0;
					next_boundary_q <= '0;
				end
			endcase
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.res_load;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign found_index   = found_index_q;
	assign next_boundary = next_boundary_q;

	// every result load gives exactly one strobe
	a_load_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> done)
		else $error("result load without strobe");

	// a probe is only issued over a non-empty interval
	a_probe_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_mid |-> (lo_q < hi_q))
		else $error("probe issued with collapsed bounds");

	// last-entry results report the clamped last index
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q == ST_LAST) |-> (found_index == INDEX_W'(hi_q)))
		else $error("last entry result has wrong index");

endmodule

// ===== rtl/core/sorted_symbol_range_lookup_unit.sv =====
// top level of the sorted symbol range lookup unit
// write beat: written to the table while idle, no result; busy stays low
// lookup beat: an empty table goes straight to the result step; else the key is rebased, the
//   ends are read and compared; a key below the first or at/above the last entry ends it; else
//   probes run until a hit or lo = hi; each is a registered dual table read, then a compare
// busy drops with done, so the next beat is taken at the edge that ends the done cycle
// reset clears control and config registers; table contents stay undefined until written
`timescale 1ns / 1ps

module sorted_symbol_range_lookup_unit import ssrl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output logic                 done,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  logic                 func,
	input  logic [INDEX_W-1:0]   write_index,
	input  logic [ADDR_W-1:0]    entry_start,
	input  logic [ADDR_W-1:0]    query_address,
	output logic [1:0]           status,
	output logic [INDEX_W-1:0]   found_index,
	output logic [ADDR_W-1:0]    next_boundary
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	ssrl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// registers, table and compare logic
	ssrl_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.write_index   (write_index),
		.entry_start   (entry_start),
		.query_address (query_address),
		.done          (done),
		.status        (status),
		.found_index   (found_index),
		.next_boundary (next_boundary)
	);

endmodule
